@@ src/hnaa_pkg.sv @@
// ----------------------------------------------------------------------------
// hnaa_pkg
// Shared item types, result codes and constants for the NAL-array to
// Annex B converter.
// ----------------------------------------------------------------------------
package hnaa_pkg;

  // Done report status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ARRAYS = 2'd1;
  localparam logic [1:0] ST_CNT_HI    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Start code 00 00 00 01
  localparam logic [2:0] SC_LEN       = 3'd4;
  localparam logic [7:0] SC_FILL_BYTE = 8'h00;
  localparam logic [7:0] SC_LAST_BYTE = 8'h01;

  localparam logic [23:0] MAX_SIZE_RESET = 24'd65536;

  typedef struct packed {
    logic       start_of_record;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [23:0] total_length;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Results caused by one input byte: optional start code, optional
  // payload byte, optional done report (in that order)
  typedef struct packed {
    logic        sc;
    logic        has_byte;
    logic        rpt;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [23:0] total;
  } burst_t;

endpackage

@@ src/hnaa_parse.sv @@
// ----------------------------------------------------------------------------
// hnaa_parse
// Record parser: holds the walk through arrays and NAL units and works out
// which results one input byte causes.
// ----------------------------------------------------------------------------
module hnaa_parse import hnaa_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        consume,
  input  in_item_t    item,
  input  logic [23:0] max_size,
  output burst_t      burst,
  output logic        burst_any
);

  localparam int NEED_W = LENGTH_BITS + 2;
  localparam int CMP_W  = (NEED_W > 24) ? NEED_W : 24;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TYPE, PH_CNT_HI, PH_CNT_LO, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [7:0]               arrays_left_r, arrays_left_nxt;
  logic [7:0]               nals_left_r, nals_left_nxt;
  logic [7:0]               length_high_r, length_high_nxt;
  logic [15:0]              payload_left_r, payload_left_nxt;
  logic [LENGTH_BITS-1:0]   bytes_written_r, bytes_written_nxt;

  logic [15:0]              size;
  logic [NEED_W-1:0]        need;
  logic                     over;
  logic [7:0]               nal_dec, arr_dec;
  logic [15:0]              pay_dec;
  logic [CMP_W-1:0]         bw_ext;

  assign size    = {length_high_r, item.data_byte};
  assign need    = NEED_W'(bytes_written_r) + NEED_W'(size) + NEED_W'(SC_LEN);
  assign over    = CMP_W'(need) > CMP_W'(max_size);
  assign nal_dec = nals_left_r - 8'd1;
  assign arr_dec = arrays_left_r - 8'd1;
  assign pay_dec = payload_left_r - 16'd1;
  assign bw_ext  = CMP_W'(bytes_written_nxt);

  // Next state and results for the byte in the input register
  always_comb begin
    phase_nxt         = phase_r;
    arrays_left_nxt   = arrays_left_r;
    nals_left_nxt     = nals_left_r;
    length_high_nxt   = length_high_r;
    payload_left_nxt  = payload_left_r;
    bytes_written_nxt = bytes_written_r;
    burst.sc          = 1'b0;
    burst.has_byte    = 1'b0;
    burst.rpt         = 1'b0;
    burst.data        = item.data_byte;
    burst.status      = ST_OK;

    if (item.start_of_record) begin
      bytes_written_nxt = '0;
      if (item.data_byte == 8'd0) begin
        burst.rpt    = 1'b1;
        burst.status = ST_NO_ARRAYS;
        phase_nxt    = PH_IDLE;
      end else begin
        arrays_left_nxt = item.data_byte;
        phase_nxt       = PH_TYPE;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_TYPE: phase_nxt = PH_CNT_HI;
        PH_CNT_HI: begin
          if (item.data_byte != 8'd0) begin
            burst.rpt    = 1'b1;
            burst.status = ST_CNT_HI;
            phase_nxt    = PH_IDLE;
          end else begin
            phase_nxt = PH_CNT_LO;
          end
        end
        PH_CNT_LO: begin
          nals_left_nxt = item.data_byte;
          if (item.data_byte == 8'd0) begin
            // empty array
            arrays_left_nxt = arr_dec;
            if (arr_dec == 8'd0) begin
              burst.rpt = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_TYPE;
            end
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          length_high_nxt = item.data_byte;
          phase_nxt       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (over) begin
            burst.rpt    = 1'b1;
            burst.status = ST_OVERFLOW;
            phase_nxt    = PH_IDLE;
          end else begin
            burst.sc          = 1'b1;
            bytes_written_nxt = need[LENGTH_BITS-1:0];
            if (size == 16'd0) begin
              // empty NAL unit: the start code but no payload
              nals_left_nxt = nal_dec;
              if (nal_dec == 8'd0) begin
                arrays_left_nxt = arr_dec;
                if (arr_dec == 8'd0) begin
                  burst.rpt = 1'b1;
                  phase_nxt = PH_IDLE;
                end else begin
                  phase_nxt = PH_TYPE;
                end
              end else begin
                phase_nxt = PH_LEN_HI;
              end
            end else begin
              payload_left_nxt = size;
              phase_nxt        = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          burst.has_byte   = 1'b1;
          payload_left_nxt = pay_dec;
          if (pay_dec == 16'd0) begin
            nals_left_nxt = nal_dec;
            if (nal_dec == 8'd0) begin
              arrays_left_nxt = arr_dec;
              if (arr_dec == 8'd0) begin
                burst.rpt = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_TYPE;
              end
            end else begin
              phase_nxt = PH_LEN_HI;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    burst.total = bw_ext[23:0];
  end

  assign burst_any = burst.sc | burst.has_byte | burst.rpt;

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      arrays_left_r   <= '0;
      nals_left_r     <= '0;
      length_high_r   <= '0;
      payload_left_r  <= '0;
      bytes_written_r <= '0;
    end else if (consume) begin
      phase_r         <= phase_nxt;
      arrays_left_r   <= arrays_left_nxt;
      nals_left_r     <= nals_left_nxt;
      length_high_r   <= length_high_nxt;
      payload_left_r  <= payload_left_nxt;
      bytes_written_r <= bytes_written_nxt;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> payload_left_r != 16'd0)
    else $error("payload phase with no bytes left");

  a_arrays_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> arrays_left_r != 8'd0)
    else $error("record open with no arrays left");

  a_nals_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEN_HI || phase_r == PH_LEN_LO) |-> nals_left_r != 8'd0)
    else $error("NAL length expected with no NAL units left");

endmodule

@@ src/hnaa_emit.sv @@
// ----------------------------------------------------------------------------
// hnaa_emit
// Result sequencer: holds the results of one input byte and moves them one
// per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module hnaa_emit import hnaa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      burst_valid,
  input  burst_t    burst,
  output logic      burst_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      bst_valid_r;
  burst_t    bst_r;
  logic [2:0] pos_r, cnt_r, ndat_r;
  logic [2:0] ld_ndat, ld_cnt;
  logic      out_valid_r;
  out_item_t out_item_r, cur;
  logic      out_ld, emit, emit_last, load;

  assign out_ld      = ~out_valid_r | ~out_stall;
  assign emit        = bst_valid_r & out_ld;
  assign emit_last   = emit & (pos_r == cnt_r - 3'd1);
  assign burst_ready = ~bst_valid_r | emit_last;
  assign load        = burst_valid & burst_ready;

  // Result counts of an incoming burst
  assign ld_ndat = burst.sc ? SC_LEN : {2'b00, burst.has_byte};
  assign ld_cnt  = ld_ndat + {2'b00, burst.rpt};

  // Current result
  always_comb begin
    cur = '0;
    if (pos_r < ndat_r) begin
      cur.kind = KIND_BYTE;
      if (bst_r.sc)
        cur.out_byte = (pos_r == SC_LEN - 3'd1) ? SC_LAST_BYTE : SC_FILL_BYTE;
      else
        cur.out_byte = bst_r.data;
    end else begin
      cur.kind         = KIND_REPORT;
      cur.total_length = bst_r.total;
      cur.status       = bst_r.status;
    end
    cur.last = (pos_r == cnt_r - 3'd1);
  end

  // Burst register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_valid_r <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      ndat_r      <= '0;
    end else if (load) begin
      bst_valid_r <= 1'b1;
      pos_r       <= '0;
      cnt_r       <= ld_cnt;
      ndat_r      <= ld_ndat;
    end else if (emit_last) begin
      bst_valid_r <= 1'b0;
    end else if (emit) begin
      pos_r <= pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) bst_r <= burst;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_item_r <= cur;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    bst_valid_r |-> (pos_r < cnt_r && ndat_r <= cnt_r))
    else $error("result position beyond burst");

  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.kind == KIND_REPORT |-> out_item_r.last)
    else $error("done report not last result of its item");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bst_valid_r && !emit_last |-> !load)
    else $error("burst overwritten before fully sent");

endmodule

@@ src/hevc_nal_arrays_to_annexb_core.sv @@
// ----------------------------------------------------------------------------
// hevc_nal_arrays_to_annexb_core
// Converts the NAL-array section of an HEVC configuration record, one byte
// per item, into an Annex B byte stream followed by a done report.
// ----------------------------------------------------------------------------
// A payload byte goes through the input register, the result sequencer and
// the output register before it reaches the output port; payload runs at one
// byte per cycle while the output is not stalled. A NAL length low byte that
// fits the buffer produces its four-byte start code (plus a done report when
// it closes the record). The output register sends one result per cycle
// while the output is not stalled, so the sequencer stays busy until the last
// result has gone, and the next byte that produces a result waits in the
// input register, stalling the input side. Header bytes that produce nothing
// pass at one per cycle. The output buffer size (cfg_wdata) is written with
// cfg_we and must only change while no record is in flight.
module hevc_nal_arrays_to_annexb_core import hnaa_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic [23:0] max_size_r;
  burst_t      burst;
  logic        burst_any, burst_ready, consume;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RESET;
    end else if (cfg_we) begin
      max_size_r <= cfg_wdata;
    end
  end

  // Input register: a byte leaves when its results fit in the sequencer
  assign consume  = in_valid_r & (burst_ready | ~burst_any);
  assign in_stall = in_valid_r & ~consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_item;
  end

  hnaa_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .consume  (consume),
    .item     (in_item_r),
    .max_size (max_size_r),
    .burst    (burst),
    .burst_any(burst_any)
  );

  hnaa_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst_valid(consume & burst_any),
    .burst      (burst),
    .burst_ready(burst_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

@@ tb/hevc_nal_arrays_to_annexb_core_tb.sv @@
// ----------------------------------------------------------------------------
// hevc_nal_arrays_to_annexb_core_tb
// Self-checking bench for the NAL-array to Annex B converter. Bytes of
// configuration records go in; a scoreboard walks each accepted byte through
// its own copy of the record parser. The scoreboard then checks every Annex B
// byte and every done report that comes out, field by field, in order.
// A short directed opening is followed by random records under several
// buffer sizes and several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module hevc_nal_arrays_to_annexb_core_tb;
  import hnaa_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 25;
  localparam int NUM_PHASES    = 5;

  // Where the parser stands inside a record
  typedef enum logic [2:0] {
    AWAIT_RECORD,
    AT_TYPE,
    AT_COUNT_HI,
    AT_COUNT_LO,
    AT_LEN_HI,
    AT_LEN_LO,
    IN_PAYLOAD
  } rec_phase_e;

  // Parser copy plus the queue of Annex B results still owed by the block
  class annexb_scoreboard;
    logic [23:0] max_size;
    rec_phase_e  phase;
    logic [7:0]  arrays_left;
    logic [7:0]  nals_left;
    logic [7:0]  len_high;
    logic [15:0] payload_left;
    logic [23:0] written;
    out_item_t   expected_stream[$];
    out_item_t   byte_results[$];
    int          errors;

    function new();
      max_size     = MAX_SIZE_RESET;
      phase        = AWAIT_RECORD;
      arrays_left  = '0;
      nals_left    = '0;
      len_high     = '0;
      payload_left = '0;
      written      = '0;
      errors       = 0;
    endfunction

    function void emit(logic kind, logic [7:0] value, logic [23:0] total, logic [1:0] st);
      out_item_t r;
      r.kind         = kind;
      r.out_byte     = value;
      r.total_length = total;
      r.status       = st;
      r.last         = 1'b0;
      byte_results.push_back(r);
    endfunction

    function void close_record(logic [1:0] st);
      emit(KIND_REPORT, 8'h00, written, st);
      phase = AWAIT_RECORD;
    endfunction

    function void finish_array();
      arrays_left = arrays_left - 8'd1;
      if (arrays_left == 8'd0) close_record(ST_OK);
      else phase = AT_TYPE;
    endfunction

    function void finish_nal();
      nals_left = nals_left - 8'd1;
      if (nals_left == 8'd0) finish_array();
      else phase = AT_LEN_HI;
    endfunction

    // Accepted input byte: work out the results it causes
    function void note_byte(in_item_t it);
      logic [15:0] nal_size;
      logic [24:0] need;
      byte_results.delete();
      if (it.start_of_record) begin
        written = '0;
        if (it.data_byte == 8'd0) close_record(ST_NO_ARRAYS);
        else begin
          arrays_left = it.data_byte;
          phase       = AT_TYPE;
        end
      end else begin
        case (phase)
          AT_TYPE: phase = AT_COUNT_HI;
          AT_COUNT_HI: begin
            if (it.data_byte != 8'd0) close_record(ST_CNT_HI);
            else phase = AT_COUNT_LO;
          end
          AT_COUNT_LO: begin
            nals_left = it.data_byte;
            if (it.data_byte == 8'd0) finish_array();
            else phase = AT_LEN_HI;
          end
          AT_LEN_HI: begin
            len_high = it.data_byte;
            phase    = AT_LEN_LO;
          end
          AT_LEN_LO: begin
            nal_size = {len_high, it.data_byte};
            need     = {1'b0, written} + 25'd4 + {9'd0, nal_size};
            if (need > {1'b0, max_size}) close_record(ST_OVERFLOW);
            else begin
              for (int i = 0; i < SC_LEN; i++)
                emit(KIND_BYTE, (i == SC_LEN - 1) ? SC_LAST_BYTE : SC_FILL_BYTE, '0, ST_OK);
              written = need[23:0];
              if (nal_size == 16'd0) finish_nal();
              else begin
                payload_left = nal_size;
                phase        = IN_PAYLOAD;
              end
            end
          end
          IN_PAYLOAD: begin
            emit(KIND_BYTE, it.data_byte, '0, ST_OK);
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0) finish_nal();
          end
          default: phase = AWAIT_RECORD;
        endcase
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
      foreach (byte_results[i]) expected_stream.push_back(byte_results[i]);
    endfunction

    function void compare(string field, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    // Accepted result: compare against the oldest owed result
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_stream.size() == 0) begin
        $error("unexpected result: kind %0d out_byte %0h total_length %0h status %0d",
               got.kind, got.out_byte, got.total_length, got.status);
        errors++;
        return;
      end
      want = expected_stream.pop_front();
      compare("kind", want.kind, got.kind);
      compare("out_byte", want.out_byte, got.out_byte);
      compare("total_length", want.total_length, got.total_length);
      compare("status", want.status, got.status);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [23:0] cfg_wdata;

  annexb_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int items_sent;
  int room;
  logic cut;

  hevc_nal_arrays_to_annexb_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Monitors: both sides sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_byte(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one item at a falling edge and hold it until accepted
  task automatic send_byte(logic sor, logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= {sor, value};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Record byte: counted, and stops the record when it is cut short or closed
  task automatic record_byte(logic sor, logic [7:0] value);
    if (!cut) begin
      send_byte(sor, value);
      items_sent++;
      if (room > 0) begin
        room--;
        if (room == 0) cut = 1'b1;
      end
      if (sb.phase == AWAIT_RECORD) cut = 1'b1;
    end
  endtask

  // Mostly well-formed record with random content; some are broken off early
  task automatic send_record();
    int n_arr;
    int n_nal;
    int hi;
    int len;
    cut   = 1'b0;
    room  = ($urandom_range(7) == 0) ? $urandom_range(2, 30) : 0;
    n_arr = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(1, 3);
    if (n_arr > 3 && room == 0) room = $urandom_range(2, 30);
    record_byte(1'b1, n_arr[7:0]);
    for (int a = 0; a < n_arr && !cut; a++) begin
      record_byte(1'b0, 8'($urandom_range(255)));
      hi = ($urandom_range(15) == 0) ? $urandom_range(1, 255) : 0;
      record_byte(1'b0, hi[7:0]);
      n_nal = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(0, 3);
      if (n_nal > 3 && room == 0) room = $urandom_range(2, 30);
      record_byte(1'b0, n_nal[7:0]);
      for (int k = 0; k < n_nal && !cut; k++) begin
        len = ($urandom_range(11) == 0) ? $urandom_range(65535) : $urandom_range(0, 6);
        if (len > 16 && room == 0) room = $urandom_range(2, 30);
        record_byte(1'b0, len[15:8]);
        record_byte(1'b0, len[7:0]);
        for (int i = 0; i < len && !cut; i++) record_byte(1'b0, 8'($urandom_range(255)));
      end
    end
  endtask

  // Hold the sender until everything owed has come out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_stream.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_size(logic [23:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we      <= 1'b0;
    sb.max_size = value;
  endtask

  initial begin
    logic [8:0]  opening [28];
    logic [23:0] sizes [NUM_PHASES];
    sb             = new();
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    items_sent     = 0;
    room           = 0;
    cut            = 1'b0;

    // Directed opening: {start_of_record, data_byte}
    opening = '{
      9'h0A5,                                 // stray byte while idle
      9'h100,                                 // record with no arrays
      9'h102, 9'h020, 9'h000, 9'h002,         // two arrays, first holds two NALs
      9'h000, 9'h003, 9'h0FF, 9'h000, 9'h080, // three-byte NAL
      9'h000, 9'h000,                         // empty NAL
      9'h021, 9'h000, 9'h000,                 // empty array closes the record
      9'h101, 9'h0FF, 9'h080,                 // nonzero count high byte
      9'h055,                                 // ignored after the error
      9'h17F, 9'h01F,                         // record dropped by a restart
      9'h101, 9'h022, 9'h000, 9'h001,
      9'h0FF, 9'h0FF                          // largest NAL overflows the buffer
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening[i]) send_byte(opening[i][8], opening[i][7:0]);

    sizes[0] = 24'hFFFFFF;
    sizes[1] = 24'($urandom_range(4, 60));
    sizes[2] = 24'd0;
    sizes[3] = 24'($urandom_range(30, 200));
    sizes[4] = MAX_SIZE_RESET;

    // Random phases: new buffer size each time and an idling mix chosen by phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_max_size(sizes[p]);
      send_idle_pct  = (p % 4 == 1) ? 83 : (p % 4 == 3) ? 8 : 0;
      recv_stall_pct = (p % 4 == 2) ? 83 : (p % 4 == 3) ? 8 : 0;
      items_sent     = 0;
      while (items_sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0)
          send_byte($urandom_range(15) == 0, 8'($urandom_range(255)));
        else
          send_record();
      end
      // Zero-count record brings the parser back to idle
      send_byte(1'b1, 8'h00);
    end
    settle();

    if (sb.errors == 0 && sb.expected_stream.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
